// File: src/gpio_prb_pkg.sv
`default_nettype none

package gpio_prb_pkg;

	localparam int LOW_W         = 32;
	localparam int HIGH_W        = 22;
	localparam int IDX_W         = 6;
	localparam int FSEL_W        = 30;
	localparam int FSEL_WORDS    = 6;
	localparam int FSEL_IDX_W    = $clog2(FSEL_WORDS);
	localparam int PINS_PER_FSEL = 10;
	localparam int MODE_W        = 3;
	localparam int PULL_W        = 2;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [IDX_W-1:0] W_SET_LO  = 6'd7;
	localparam logic [IDX_W-1:0] W_SET_HI  = 6'd8;
	localparam logic [IDX_W-1:0] W_CLR_LO  = 6'd10;
	localparam logic [IDX_W-1:0] W_CLR_HI  = 6'd11;
	localparam logic [IDX_W-1:0] W_LEV_LO  = 6'd13;
	localparam logic [IDX_W-1:0] W_LEV_HI  = 6'd14;
	localparam logic [IDX_W-1:0] W_PULL    = 6'd37;
	localparam logic [IDX_W-1:0] W_PCLK_LO = 6'd38;
	localparam logic [IDX_W-1:0] W_PCLK_HI = 6'd39;

	localparam logic [MODE_W-1:0] MODE_OUT = 3'd1;

	localparam logic [PULL_W-1:0] PULL_NONE = 2'd0;
	localparam logic [PULL_W-1:0] PULL_DN   = 2'd1;
	localparam logic [PULL_W-1:0] PULL_UP   = 2'd2;

	typedef struct packed {
		logic              opcode;
		logic [IDX_W-1:0]  word_index;
		logic [LOW_W-1:0]  write_data;
		logic [LOW_W-1:0]  pins_in_low;
		logic [HIGH_W-1:0] pins_in_high;
	} item_t;

	typedef struct packed {
		logic [LOW_W-1:0]  read_data;
		logic [LOW_W-1:0]  drive_low;
		logic [HIGH_W-1:0] drive_high;
		logic [LOW_W-1:0]  enable_low;
		logic [HIGH_W-1:0] enable_high;
		logic [LOW_W-1:0]  pullup_low;
		logic [HIGH_W-1:0] pullup_high;
		logic [LOW_W-1:0]  pulldown_low;
		logic [HIGH_W-1:0] pulldown_high;
	} result_t;

endpackage

`default_nettype wire

// File: src/gpio_prb_req_if.sv
`default_nettype none

interface gpio_prb_req_if;
	import gpio_prb_pkg::*;

	logic              valid;
	logic              ready;
	logic              opcode;
	logic [IDX_W-1:0]  word_index;
	logic [LOW_W-1:0]  write_data;
	logic [LOW_W-1:0]  pins_in_low;
	logic [HIGH_W-1:0] pins_in_high;

	modport source (
		output valid, opcode, word_index, write_data, pins_in_low, pins_in_high,
		input  ready
	);

	modport sink (
		input  valid, opcode, word_index, write_data, pins_in_low, pins_in_high,
		output ready
	);
endinterface

`default_nettype wire

// File: src/gpio_prb_rsp_if.sv
`default_nettype none

interface gpio_prb_rsp_if;
	import gpio_prb_pkg::*;

	logic              valid;
	logic              ready;
	logic [LOW_W-1:0]  read_data;
	logic [LOW_W-1:0]  drive_low;
	logic [HIGH_W-1:0] drive_high;
	logic [LOW_W-1:0]  enable_low;
	logic [HIGH_W-1:0] enable_high;
	logic [LOW_W-1:0]  pullup_low;
	logic [HIGH_W-1:0] pullup_high;
	logic [LOW_W-1:0]  pulldown_low;
	logic [HIGH_W-1:0] pulldown_high;

	modport source (
		output valid, read_data, drive_low, drive_high, enable_low, enable_high,
		       pullup_low, pullup_high, pulldown_low, pulldown_high,
		input  ready
	);

	modport sink (
		input  valid, read_data, drive_low, drive_high, enable_low, enable_high,
		       pullup_low, pullup_high, pulldown_low, pulldown_high,
		output ready
	);
endinterface

`default_nettype wire

// File: src/gpio_prb_regs.sv
`default_nettype none

module gpio_prb_regs #(
	parameter int NUM_PINS = 54
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  gpio_prb_pkg::item_t   item,
	output gpio_prb_pkg::result_t result
);
	import gpio_prb_pkg::*;

	// pins of the high bank that exist and can be seen on the ports
	localparam int HI_PINS   = (NUM_PINS - LOW_W < HIGH_W) ? NUM_PINS - LOW_W : HIGH_W;
	localparam int PULL_PINS = LOW_W + HI_PINS;
	localparam logic [HIGH_W-1:0] HI_MASK = HIGH_W'((64'd1 << HI_PINS) - 64'd1);

	logic [FSEL_W-1:0] fsel_q [FSEL_WORDS];
	logic [FSEL_W-1:0] fsel_d [FSEL_WORDS];
	logic [LOW_W-1:0]  latch_lo_q, latch_lo_d;
	logic [HIGH_W-1:0] latch_hi_q, latch_hi_d;
	logic [PULL_W-1:0] pull_ctl_q, pull_ctl_d;
	logic [PULL_W-1:0] pull_q [PULL_PINS];
	logic [PULL_W-1:0] pull_d [PULL_PINS];

	logic              wr;
	logic [LOW_W-1:0]  en_lo_cur, en_lo_nxt;
	logic [HIGH_W-1:0] en_hi_cur, en_hi_nxt;
	logic [LOW_W-1:0]  lev_lo, rd;
	logic [HIGH_W-1:0] lev_hi;
	logic [LOW_W-1:0]  up_lo, dn_lo;
	logic [HIGH_W-1:0] up_hi, dn_hi;

	assign wr = (item.opcode == OP_WRITE);

	always_comb begin
		for (int w = 0; w < FSEL_WORDS; w++) begin
			fsel_d[w] = (wr && item.word_index == IDX_W'(w)) ?
				item.write_data[FSEL_W-1:0] : fsel_q[w];
		end
	end

	always_comb begin
		latch_lo_d = latch_lo_q;
		latch_hi_d = latch_hi_q;
		if (wr) begin
			unique case (item.word_index)
				W_SET_LO: latch_lo_d = latch_lo_q | item.write_data;
				W_SET_HI: latch_hi_d = latch_hi_q | (item.write_data[HIGH_W-1:0] & HI_MASK);
				W_CLR_LO: latch_lo_d = latch_lo_q & ~item.write_data;
				W_CLR_HI: latch_hi_d = latch_hi_q & ~item.write_data[HIGH_W-1:0];
				default: ;
			endcase
		end
	end

	assign pull_ctl_d = (wr && item.word_index == W_PULL) ?
		item.write_data[PULL_W-1:0] : pull_ctl_q;

	// latch the pull control into every pin whose bit is set in the bank write
	always_comb begin
		for (int p = 0; p < PULL_PINS; p++) begin
			if (wr && item.word_index == ((p < LOW_W) ? W_PCLK_LO : W_PCLK_HI) &&
			    item.write_data[p % LOW_W])
				pull_d[p] = pull_ctl_q;
			else
				pull_d[p] = pull_q[p];
		end
	end

	always_comb begin
		for (int b = 0; b < LOW_W; b++) begin
			en_lo_cur[b] = (fsel_q[b / PINS_PER_FSEL][MODE_W * (b % PINS_PER_FSEL) +: MODE_W]
				== MODE_OUT);
			en_lo_nxt[b] = (fsel_d[b / PINS_PER_FSEL][MODE_W * (b % PINS_PER_FSEL) +: MODE_W]
				== MODE_OUT);
		end
		for (int b = 0; b < HIGH_W; b++) begin
			en_hi_cur[b] = (fsel_q[(b + LOW_W) / PINS_PER_FSEL]
				[MODE_W * ((b + LOW_W) % PINS_PER_FSEL) +: MODE_W] == MODE_OUT) && HI_MASK[b];
			en_hi_nxt[b] = (fsel_d[(b + LOW_W) / PINS_PER_FSEL]
				[MODE_W * ((b + LOW_W) % PINS_PER_FSEL) +: MODE_W] == MODE_OUT) && HI_MASK[b];
		end
	end

	// level words: latch for output pins, sampled input for the rest
	assign lev_lo = (latch_lo_q & en_lo_cur) | (item.pins_in_low & ~en_lo_cur);
	assign lev_hi = ((latch_hi_q & en_hi_cur) | (item.pins_in_high & ~en_hi_cur)) & HI_MASK;

	always_comb begin
		rd = '0;
		if (!wr) begin
			if (item.word_index < IDX_W'(FSEL_WORDS)) begin
				rd = LOW_W'(fsel_q[item.word_index[FSEL_IDX_W-1:0]]);
			end else begin
				unique case (item.word_index)
					W_LEV_LO: rd = lev_lo;
					W_LEV_HI: rd = LOW_W'(lev_hi);
					W_PULL:   rd = LOW_W'(pull_ctl_q);
					default:  rd = '0;
				endcase
			end
		end
	end

	always_comb begin
		for (int p = 0; p < LOW_W; p++) begin
			up_lo[p] = (pull_d[p] == PULL_UP);
			dn_lo[p] = (pull_d[p] == PULL_DN);
		end
	end

	for (genvar b = 0; b < HIGH_W; b++) begin : g_hi_pull
		if (b < HI_PINS) begin : g_on
			assign up_hi[b] = (pull_d[b + LOW_W] == PULL_UP);
			assign dn_hi[b] = (pull_d[b + LOW_W] == PULL_DN);
		end else begin : g_off
			assign up_hi[b] = 1'b0;
			assign dn_hi[b] = 1'b0;
		end
	end

	assign result.read_data     = rd;
	assign result.drive_low     = latch_lo_d;
	assign result.drive_high    = latch_hi_d;
	assign result.enable_low    = en_lo_nxt;
	assign result.enable_high   = en_hi_nxt;
	assign result.pullup_low    = up_lo;
	assign result.pullup_high   = up_hi;
	assign result.pulldown_low  = dn_lo;
	assign result.pulldown_high = dn_hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < FSEL_WORDS; w++) fsel_q[w] <= '0;
			latch_lo_q <= '0;
			latch_hi_q <= '0;
			pull_ctl_q <= PULL_NONE;
			for (int p = 0; p < PULL_PINS; p++) pull_q[p] <= PULL_NONE;
		end else if (step) begin
			for (int w = 0; w < FSEL_WORDS; w++) fsel_q[w] <= fsel_d[w];
			latch_lo_q <= latch_lo_d;
			latch_hi_q <= latch_hi_d;
			pull_ctl_q <= pull_ctl_d;
			for (int p = 0; p < PULL_PINS; p++) pull_q[p] <= pull_d[p];
		end
	end

	a_write_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		step && wr |-> result.read_data == '0)
		else $error("write access returned non-zero read data");

	a_pull_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> ((result.pullup_low & result.pulldown_low) == '0) &&
		         ((result.pullup_high & result.pulldown_high) == '0))
		else $error("pin shows pull-up and pull-down together");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(latch_lo_q) && $stable(latch_hi_q) && $stable(pull_ctl_q))
		else $error("register state changed without an access");

	a_absent_pins_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(latch_hi_q & ~HI_MASK) == '0)
		else $error("output latch holds a bit of an absent pin");

endmodule

`default_nettype wire

// File: src/gpio_port_register_block_core.sv
// An access waits in the input register until the result register is free or draining,
// is then loaded into the result register together with the register file update, and
// transfers out when the result side is not stalled.
// Throughput: one access per cycle while the result side is not stalled.
// Reset: asynchronous, active low; clears function selects, output latch and pull state.
`default_nettype none

module gpio_port_register_block_core #(
	parameter int NUM_PINS = 54
) (
	input  logic                  clk,
	input  logic                  arst_n,
	gpio_prb_req_if.sink          req,
	gpio_prb_rsp_if.source        rsp
);
	import gpio_prb_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t res_c;
	logic    adv;

	// advance the held access whenever the result register is free or draining
	assign adv       = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	gpio_prb_regs #(
		.NUM_PINS (NUM_PINS)
	) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.result (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req.ready)
				valid_s1 <= req.valid;
			if (adv)
				valid_s2 <= 1'b1;
			else if (rsp.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.opcode       <= req.opcode;
			item_s1.word_index   <= req.word_index;
			item_s1.write_data   <= req.write_data;
			item_s1.pins_in_low  <= req.pins_in_low;
			item_s1.pins_in_high <= req.pins_in_high;
		end
		if (adv)
			res_s2 <= res_c;
	end

	assign rsp.valid         = valid_s2;
	assign rsp.read_data     = res_s2.read_data;
	assign rsp.drive_low     = res_s2.drive_low;
	assign rsp.drive_high    = res_s2.drive_high;
	assign rsp.enable_low    = res_s2.enable_low;
	assign rsp.enable_high   = res_s2.enable_high;
	assign rsp.pullup_low    = res_s2.pullup_low;
	assign rsp.pullup_high   = res_s2.pullup_high;
	assign rsp.pulldown_low  = res_s2.pulldown_low;
	assign rsp.pulldown_high = res_s2.pulldown_high;

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("held access dropped before it advanced");

	a_adv_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("advanced access did not reach the result register");

	a_no_needless_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> req.ready)
		else $error("input stalled while the result register is empty");

endmodule

`default_nettype wire

// File: verif/tb.sv
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gpio_prb_pkg::*;

	localparam int PIN_TOTAL = LOW_W + HIGH_W;
	localparam int N_RANDOM = 800;
	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_CYCLES = 10;

	// words outside the map, then the first and last select words
	localparam logic [IDX_W-1:0] W_HOLE_FSEL = 6'd6;
	localparam logic [IDX_W-1:0] W_HOLE_SET  = 6'd12;
	localparam logic [IDX_W-1:0] W_HOLE_HIGH = 6'd44;
	localparam logic [IDX_W-1:0] W_HOLE_TOP  = 6'd63;
	localparam logic [IDX_W-1:0] W_FSEL_FIRST = 6'd0;
	localparam logic [IDX_W-1:0] W_FSEL_LAST  = IDX_W'(FSEL_WORDS - 1);

	localparam logic [LOW_W-1:0] ALL_ONES     = 32'hFFFF_FFFF;
	localparam logic [LOW_W-1:0] ALL_OUTPUT   = 32'h0924_9249;
	localparam logic [LOW_W-1:0] TOP_FSEL_MIX = 32'hFFFF_F249;

	class gpio_port_scoreboard;
		localparam int PIN_COUNT = LOW_W + HIGH_W;

		logic [FSEL_W-1:0]    fsel [FSEL_WORDS];
		logic [PIN_COUNT-1:0] latch;
		logic [PULL_W-1:0]    pull_ctrl;
		logic [PULL_W-1:0]    pin_pull [PIN_COUNT];
		result_t              due_results [$];
		int unsigned          errors, checked, reads, writes;
		int unsigned          print_limit = 40;

		function new();
			foreach (fsel[i]) fsel[i] = '0;
			foreach (pin_pull[i]) pin_pull[i] = PULL_NONE;
			latch = '0;
			pull_ctrl = PULL_NONE;
			errors = 0;
			checked = 0;
			reads = 0;
			writes = 0;
		endfunction

		function logic [PIN_COUNT-1:0] enables();
			logic [PIN_COUNT-1:0] e;
			int w;
			e = '0;
			for (int p = 0; p < PIN_COUNT; p++) begin
				w = p / PINS_PER_FSEL;
				if (w < FSEL_WORDS &&
				    fsel[w][MODE_W*(p % PINS_PER_FSEL) +: MODE_W] == MODE_OUT)
					e[p] = 1'b1;
			end
			return e;
		endfunction

		function void apply_access(item_t it);
			result_t              r;
			logic [PIN_COUNT-1:0] en, pins, lvl, up, dn;
			r = '0;
			pins = {it.pins_in_high, it.pins_in_low};
			if (it.opcode == OP_WRITE) begin
				writes++;
				if (it.word_index < FSEL_WORDS) begin
					fsel[it.word_index[FSEL_IDX_W-1:0]] = it.write_data[FSEL_W-1:0];
				end else begin
					case (it.word_index)
						W_SET_LO: latch[LOW_W-1:0] |= it.write_data;
						W_SET_HI: latch[PIN_COUNT-1:LOW_W] |= it.write_data[HIGH_W-1:0];
						W_CLR_LO: latch[LOW_W-1:0] &= ~it.write_data;
						W_CLR_HI: latch[PIN_COUNT-1:LOW_W] &= ~it.write_data[HIGH_W-1:0];
						W_PULL: pull_ctrl = it.write_data[PULL_W-1:0];
						W_PCLK_LO: begin
							for (int b = 0; b < LOW_W; b++)
								if (it.write_data[b]) pin_pull[b] = pull_ctrl;
						end
						W_PCLK_HI: begin
							for (int b = 0; b < HIGH_W; b++)
								if (it.write_data[b]) pin_pull[LOW_W+b] = pull_ctrl;
						end
						default: ;
					endcase
				end
			end else begin
				reads++;
				en = enables();
				lvl = (latch & en) | (pins & ~en);
				if (it.word_index < FSEL_WORDS) begin
					r.read_data = LOW_W'(fsel[it.word_index[FSEL_IDX_W-1:0]]);
				end else begin
					case (it.word_index)
						W_LEV_LO: r.read_data = lvl[LOW_W-1:0];
						W_LEV_HI: r.read_data = LOW_W'(lvl[PIN_COUNT-1:LOW_W]);
						W_PULL: r.read_data = LOW_W'(pull_ctrl);
						default: r.read_data = '0;
					endcase
				end
			end
			en = enables();
			for (int p = 0; p < PIN_COUNT; p++) begin
				up[p] = (pin_pull[p] == PULL_UP);
				dn[p] = (pin_pull[p] == PULL_DN);
			end
			r.drive_low     = latch[LOW_W-1:0];
			r.drive_high    = latch[PIN_COUNT-1:LOW_W];
			r.enable_low    = en[LOW_W-1:0];
			r.enable_high   = en[PIN_COUNT-1:LOW_W];
			r.pullup_low    = up[LOW_W-1:0];
			r.pullup_high   = up[PIN_COUNT-1:LOW_W];
			r.pulldown_low  = dn[LOW_W-1:0];
			r.pulldown_high = dn[PIN_COUNT-1:LOW_W];
			due_results.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= print_limit)
				$display("%0t ns mismatch: %s", $time, msg);
		endtask

		task compare(string name, logic [LOW_W-1:0] got, logic [LOW_W-1:0] want);
			if (got !== want)
				report($sformatf("%s got %h want %h", name, got, want));
		endtask

		task check_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				report("result transfer with nothing outstanding");
				return;
			end
			want = due_results.pop_front();
			checked++;
			compare("read_data", got.read_data, want.read_data);
			compare("drive_low", got.drive_low, want.drive_low);
			compare("drive_high", LOW_W'(got.drive_high), LOW_W'(want.drive_high));
			compare("enable_low", got.enable_low, want.enable_low);
			compare("enable_high", LOW_W'(got.enable_high), LOW_W'(want.enable_high));
			compare("pullup_low", got.pullup_low, want.pullup_low);
			compare("pullup_high", LOW_W'(got.pullup_high), LOW_W'(want.pullup_high));
			compare("pulldown_low", got.pulldown_low, want.pulldown_low);
			compare("pulldown_high", LOW_W'(got.pulldown_high),
			        LOW_W'(want.pulldown_high));
		endtask
	endclass

	logic clk;
	logic arst_n;

	gpio_prb_req_if req_ch();
	gpio_prb_rsp_if rsp_ch();

	gpio_port_register_block_core #(.NUM_PINS(PIN_TOTAL)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	gpio_port_scoreboard sb;
	int unsigned idle_cycles;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// drive one access and hold it until the transfer
	task automatic send(item_t it);
		@(negedge clk);
		req_ch.valid        <= 1'b1;
		req_ch.opcode       <= it.opcode;
		req_ch.word_index   <= it.word_index;
		req_ch.write_data   <= it.write_data;
		req_ch.pins_in_low  <= it.pins_in_low;
		req_ch.pins_in_high <= it.pins_in_high;
		do @(posedge clk); while (!req_ch.ready);
		sb.apply_access(it);
	endtask

	task automatic access(logic op, logic [IDX_W-1:0] idx, logic [LOW_W-1:0] data,
	                      logic [LOW_W-1:0] plo = '0, logic [HIGH_W-1:0] phi = '0);
		item_t it;
		it.opcode       = op;
		it.word_index   = idx;
		it.write_data   = data;
		it.pins_in_low  = plo;
		it.pins_in_high = phi;
		send(it);
	endtask

	task automatic pause(int unsigned n);
		if (n > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// hold off until every outstanding result has been seen
	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (sb.due_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic [LOW_W-1:0] random_fsel_word();
		logic [LOW_W-1:0] d;
		d = $urandom;
		for (int p = 0; p < PINS_PER_FSEL; p++)
			if ($urandom_range(0, 3) != 0)
				d[MODE_W*p +: MODE_W] = MODE_W'($urandom_range(0, 1));
		return d;
	endfunction

	function automatic item_t random_access();
		item_t       it;
		int unsigned k;
		k = $urandom_range(0, 99);
		it.opcode       = OP_READ;
		it.write_data   = $urandom;
		it.pins_in_low  = $urandom;
		it.pins_in_high = HIGH_W'($urandom);
		case ($urandom_range(0, 9))
			0: it.pins_in_low = '0;
			1: it.pins_in_low = ALL_ONES;
			2: it.pins_in_high = '1;
			default: ;
		endcase
		if ($urandom_range(0, 4) == 0)
			it.write_data = $urandom & $urandom & $urandom;
		if (k < 18) begin
			it.opcode     = OP_WRITE;
			it.word_index = IDX_W'($urandom_range(0, FSEL_WORDS - 1));
			it.write_data = random_fsel_word();
		end else if (k < 30) begin
			it.word_index = IDX_W'($urandom_range(0, FSEL_WORDS - 1));
		end else if (k < 45) begin
			it.opcode     = OP_WRITE;
			it.word_index = $urandom_range(0, 1) ? W_SET_HI : W_SET_LO;
		end else if (k < 58) begin
			it.opcode     = OP_WRITE;
			it.word_index = $urandom_range(0, 1) ? W_CLR_HI : W_CLR_LO;
		end else if (k < 75) begin
			it.word_index = $urandom_range(0, 1) ? W_LEV_HI : W_LEV_LO;
		end else if (k < 80) begin
			it.word_index = W_PULL;
		end else if (k < 88) begin
			it.opcode     = OP_WRITE;
			it.word_index = W_PULL;
		end else if (k < 93) begin
			it.opcode     = OP_WRITE;
			it.word_index = $urandom_range(0, 1) ? W_PCLK_HI : W_PCLK_LO;
		end else if (k < 96) begin
			case ($urandom_range(0, 2))
				0: it.word_index = $urandom_range(0, 1) ? W_SET_HI : W_SET_LO;
				1: it.word_index = $urandom_range(0, 1) ? W_CLR_HI : W_CLR_LO;
				default: it.word_index = $urandom_range(0, 1) ? W_PCLK_HI : W_PCLK_LO;
			endcase
		end else begin
			it.opcode     = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
			it.word_index = IDX_W'($urandom_range(0, 63));
		end
		return it;
	endfunction

	// receiver: rotate through free-running, light, sparse and heavy random stalls
	initial begin : stall_pattern
		int unsigned cyc;
		cyc = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			case ((cyc / 150) % 4)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
				2: rsp_ch.ready <= (cyc % 5 == 0);
				default: rsp_ch.ready <= ($urandom_range(0, 9) < 3);
			endcase
			cyc++;
		end
	end

	always @(posedge clk) begin
		result_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.read_data     = rsp_ch.read_data;
			got.drive_low     = rsp_ch.drive_low;
			got.drive_high    = rsp_ch.drive_high;
			got.enable_low    = rsp_ch.enable_low;
			got.enable_high   = rsp_ch.enable_high;
			got.pullup_low    = rsp_ch.pullup_low;
			got.pullup_high   = rsp_ch.pullup_high;
			got.pulldown_low  = rsp_ch.pulldown_low;
			got.pulldown_high = rsp_ch.pulldown_high;
			sb.check_result(got);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("no transfer for %0d cycles", IDLE_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int unsigned sent, burst, k;
		item_t       it;
		sb = new();
		idle_cycles = 0;
		arst_n = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.opcode       = OP_READ;
		req_ch.word_index   = '0;
		req_ch.write_data   = '0;
		req_ch.pins_in_low  = '0;
		req_ch.pins_in_high = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset state, then input levels with every input pin high
		access(OP_READ, W_FSEL_FIRST, ALL_ONES);
		access(OP_READ, W_LEV_LO, '0, ALL_ONES, '1);
		access(OP_READ, W_LEV_HI, ALL_ONES, ALL_ONES, '1);
		// function select keeps 30 bits; mode 7 is not output
		access(OP_WRITE, W_FSEL_FIRST, ALL_ONES);
		access(OP_READ, W_FSEL_FIRST, '0);
		access(OP_WRITE, W_FSEL_FIRST, ALL_OUTPUT);
		// absent pins in the last select word are still stored
		access(OP_WRITE, W_FSEL_LAST, TOP_FSEL_MIX);
		access(OP_READ, W_FSEL_LAST, '0);
		access(OP_WRITE, W_SET_LO, ALL_ONES);
		access(OP_WRITE, W_SET_HI, ALL_ONES);
		access(OP_READ, W_LEV_LO, ALL_ONES, '0, '0);
		access(OP_READ, W_LEV_HI, '0, '0, '1);
		access(OP_WRITE, W_CLR_LO, 32'hAAAA_AAAA);
		access(OP_WRITE, W_CLR_HI, ALL_ONES);
		access(OP_READ, W_SET_LO, ALL_ONES);
		access(OP_READ, W_PCLK_HI, ALL_ONES);
		// reserved pull code latched but drives neither pull
		access(OP_WRITE, W_PULL, ALL_ONES);
		access(OP_WRITE, W_PCLK_LO, 32'h0000_FFFF);
		access(OP_READ, W_PULL, '0);
		access(OP_WRITE, W_PULL, LOW_W'(PULL_UP));
		access(OP_WRITE, W_PCLK_HI, ALL_ONES);
		access(OP_WRITE, W_PULL, LOW_W'(PULL_DN));
		access(OP_WRITE, W_PCLK_LO, 32'hFFFF_0000);
		access(OP_WRITE, W_HOLE_FSEL, ALL_ONES);
		access(OP_READ, W_HOLE_TOP, ALL_ONES);
		access(OP_WRITE, W_HOLE_HIGH, ALL_ONES);
		access(OP_READ, W_HOLE_SET, ALL_ONES);
		drain();

		sent = 0;
		while (sent < N_RANDOM) begin
			burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
			                                    : $urandom_range(1, 16);
			for (int i = 0; i < burst && sent < N_RANDOM; i++) begin
				if (sent == N_RANDOM / 2)
					drain();
				k = $urandom_range(0, 9);
				if (k == 0) begin
					// pull set-up: control word then a clock write
					it = random_access();
					it.opcode     = OP_WRITE;
					it.word_index = W_PULL;
					send(it);
					it = random_access();
					it.opcode     = OP_WRITE;
					it.word_index = $urandom_range(0, 1) ? W_PCLK_HI : W_PCLK_LO;
					send(it);
					sent += 2;
				end else begin
					send(random_access());
					sent++;
				end
			end
			if ($urandom_range(0, 3) != 0)
				pause($urandom_range(1, 6));
		end
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d reads and %0d writes driven, %0d results compared",
		         sb.reads, sb.writes, sb.checked);
		$display("%0d mismatches over select, latch, level and pull paths", sb.errors);
		if (sb.errors == 0 && sb.due_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
src/gpio_prb_pkg.sv
src/gpio_prb_req_if.sv
src/gpio_prb_rsp_if.sv
src/gpio_prb_regs.sv
src/gpio_port_register_block_core.sv
verif/tb.sv
